/* src/smbs_pkg.sv */
`default_nettype none

package smbs_pkg;

	// fixed field widths
	localparam int ADDR_W = 12;
	localparam int OFF_W  = 19;
	localparam int COL_W  = 18;
	localparam int SUM_W  = 20;
	localparam int ROW_W  = 4;
	localparam int HALF_W = 4;
	localparam int CNT_W  = 5;

	// item kinds
	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_STAMP = 2'd1,
		KIND_READ  = 2'd2
	} smbs_kind_t;

	// blob shape codes
	localparam logic [2:0] SHAPE_ROW7  = 3'd0;
	localparam logic [2:0] SHAPE_ROW8  = 3'd1;
	localparam logic [2:0] SHAPE_ROW12 = 3'd2;
	localparam logic [2:0] SHAPE_ROW6  = 3'd3;
	localparam logic [2:0] SHAPE_ROW14 = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_BORDER_FRAME   = 2'd0;
	localparam logic [1:0] REG_GRADIENT_ON    = 2'd1;
	localparam logic [1:0] REG_GRADIENT_SLOPE = 2'd2;

	localparam logic [7:0] SLOPE_RESET = 8'd4;

	// half-width tables, one per shape
	localparam logic [HALF_W-1:0] HALF_S0 [14] = '{2, 3, 4, 4, 4, 3, 2, 0, 0, 0, 0, 0, 0, 0};
	localparam logic [HALF_W-1:0] HALF_S1 [14] = '{2, 3, 4, 4, 4, 4, 3, 2, 0, 0, 0, 0, 0, 0};
	localparam logic [HALF_W-1:0] HALF_S2 [14] = '{2, 4, 5, 5, 6, 6, 6, 6, 5, 5, 4, 2, 0, 0};
	localparam logic [HALF_W-1:0] HALF_S3 [14] = '{1, 2, 3, 3, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0};
	localparam logic [HALF_W-1:0] HALF_S4 [14] = '{2, 4, 5, 6, 7, 8, 8, 8, 8, 7, 6, 5, 4, 2};

	typedef struct packed {
		logic [ROW_W-1:0] rows;
		logic [2:0]       first;
		logic             narrow;
	} smbs_shape_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_STAMP_ROW,
		ST_STAMP_PIX,
		ST_READ,
		ST_DONE
	} smbs_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clr_step;
		logic clr_frame;
		logic row_load;
		logic pix_step;
		logic rd;
		logic res_load;
		logic res_read;
	} smbs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic pix_last;
		logic row_last;
	} smbs_status_t;

	// row count, centre row and narrow flag of a shape; unknown codes use the six-row shape
	function automatic smbs_shape_t shape_info(input logic [2:0] shape);
		smbs_shape_t s;
		case (shape)
			SHAPE_ROW7:  s = '{rows: 4'd7,  first: 3'd3, narrow: 1'b1};
			SHAPE_ROW8:  s = '{rows: 4'd8,  first: 3'd4, narrow: 1'b0};
			SHAPE_ROW12: s = '{rows: 4'd12, first: 3'd6, narrow: 1'b0};
			SHAPE_ROW14: s = '{rows: 4'd14, first: 3'd7, narrow: 1'b0};
			default:     s = '{rows: 4'd6,  first: 3'd2, narrow: 1'b1};
		endcase
		return s;
	endfunction

	// half-width of one shape row
	function automatic logic [HALF_W-1:0] shape_half(input logic [2:0] shape,
		input logic [ROW_W-1:0] row);
		logic [HALF_W-1:0] h;
		case (shape)
			SHAPE_ROW7:  h = HALF_S0[row];
			SHAPE_ROW8:  h = HALF_S1[row];
			SHAPE_ROW12: h = HALF_S2[row];
			SHAPE_ROW14: h = HALF_S4[row];
			default:     h = HALF_S3[row];
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

/* src/smbs_item_if.sv */
`default_nettype none

interface smbs_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [2:0]         shape;
	logic signed [15:0] center_col;
	logic signed [15:0] center_offset;
	logic [11:0]        read_address;

	modport source (output valid, kind, shape, center_col, center_offset, read_address,
		input ready);
	modport sink (input valid, kind, shape, center_col, center_offset, read_address,
		output ready);
endinterface

`default_nettype wire

/* src/smbs_result_if.sv */
`default_nettype none

interface smbs_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;

	modport source (output valid, pixel, input ready);
	modport sink (input valid, pixel, output ready);
endinterface

`default_nettype wire

/* src/smbs_datapath.sv */
`default_nettype none

module smbs_datapath
	import smbs_pkg::*;
#(
	parameter int MASK_SIDE = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire smbs_cmd_t          cmd,
	output smbs_status_t            status,
	input  wire logic [2:0]         shape,
	input  wire logic signed [15:0] center_col,
	input  wire logic signed [15:0] center_offset,
	input  wire logic [11:0]        read_address,
	input  wire logic               wr_en,
	input  wire logic [1:0]         wr_index,
	input  wire logic [7:0]         wr_data,
	output logic [7:0]              pixel
);

	localparam int STORE  = MASK_SIDE * MASK_SIDE;
	localparam int AW     = $clog2(STORE);
	localparam int SW     = $clog2(MASK_SIDE);
	// reciprocal of MASK_SIDE, exact for every ADDR_W-bit address
	localparam int DIV_SH = ADDR_W + SW;
	localparam int RCP_W  = ADDR_W + 1;
	localparam int PROD_W = DIV_SH + 8;
	localparam logic [RCP_W-1:0] ROW_RCP = RCP_W'((2 ** DIV_SH + MASK_SIDE - 1) / MASK_SIDE);

	// configuration registers
	logic       border_frame_q;
	logic       gradient_on_q;
	logic [7:0] gradient_slope_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_frame_q   <= 1'b0;
			gradient_on_q    <= 1'b0;
			gradient_slope_q <= SLOPE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BORDER_FRAME:   border_frame_q   <= wr_data[0];
				REG_GRADIENT_ON:    gradient_on_q    <= wr_data[0];
				REG_GRADIENT_SLOPE: gradient_slope_q <= wr_data;
				default: ;
			endcase
		end
	end

	// captured item fields
	logic [2:0]         shape_q;
	logic signed [15:0] ccol_q;
	logic [ADDR_W-1:0]  addr_q;
	smbs_shape_t        info_in;
	smbs_shape_t        info_q;

	assign info_in = shape_info(shape);
	assign info_q  = shape_info(shape_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shape_q <= shape;
			ccol_q  <= center_col;
			addr_q  <= read_address;
		end
	end

	// clear sweep counters, wrap to zero after the last entry
	logic [SW-1:0] clr_row_q;
	logic [SW-1:0] clr_col_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_edge;
	logic          clr_col_end;
	logic          clr_row_end;

	assign clr_col_end = clr_col_q == SW'(MASK_SIDE - 1);
	assign clr_row_end = clr_row_q == SW'(MASK_SIDE - 1);
	assign clr_edge    = clr_row_q == '0 || clr_row_end || clr_col_q == '0 || clr_col_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q  <= '0;
			clr_col_q  <= '0;
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			if (clr_col_end) begin
				clr_col_q <= '0;
				clr_row_q <= clr_row_end ? '0 : clr_row_q + 1'b1;
			end else begin
				clr_col_q <= clr_col_q + 1'b1;
			end
			clr_addr_q <= (clr_col_end && clr_row_end) ? '0 : clr_addr_q + 1'b1;
		end
	end

	// stamp walk: row index, row offset, column, pixels left in the row
	logic [ROW_W-1:0]        row_q;
	logic signed [OFF_W-1:0] off_q;
	logic signed [COL_W-1:0] col_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [HALF_W-1:0]       half;
	logic signed [SUM_W-1:0] pix_sum;
	logic                    pix_ok;

	assign half    = shape_half(shape_q, row_q);
	assign pix_sum = SUM_W'(col_q) + SUM_W'(off_q);
	assign pix_ok  = !col_q[COL_W-1] && col_q < COL_W'(MASK_SIDE)
		&& !off_q[OFF_W-1] && off_q < OFF_W'(STORE)
		&& pix_sum < SUM_W'(STORE);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_q <= '0;
			off_q <= OFF_W'(center_offset) - OFF_W'(info_in.first) * OFF_W'(MASK_SIDE);
		end else if (cmd.pix_step && status.pix_last) begin
			row_q <= row_q + 1'b1;
			off_q <= off_q + OFF_W'(MASK_SIDE);
		end
		if (cmd.row_load) begin
			col_q <= COL_W'(ccol_q) - COL_W'(half);
			cnt_q <= CNT_W'({half, 1'b0}) - CNT_W'(info_q.narrow);
		end else if (cmd.pix_step) begin
			col_q <= col_q + 1'b1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// single write port shared by clear and stamp
	logic [7:0]    mask_q [STORE];
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [7:0]    mem_wd;
	logic [7:0]    rd_q;

	always_comb begin
		mem_we = cmd.clr_step || (cmd.pix_step && pix_ok);
		if (cmd.clr_step) begin
			mem_wa = clr_addr_q;
			mem_wd = (cmd.clr_frame && border_frame_q && clr_edge) ? 8'hFF : 8'h00;
		end else begin
			mem_wa = pix_sum[AW-1:0];
			mem_wd = 8'hFF;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mask_q[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q <= mask_q[AW'(addr_q)];
		end
	end

	// row of the read address, low eight bits are enough for the fade
	logic [PROD_W-1:0] row_prod;
	logic [7:0]        fade_row_q;

	assign row_prod = PROD_W'(addr_q) * PROD_W'(ROW_RCP);

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			fade_row_q <= row_prod[DIV_SH +: 8];
		end
	end

	// read value with the optional fade
	logic        in_store;
	logic [15:0] fade_prod;
	logic [7:0]  read_val;

	assign in_store  = {20'd0, addr_q} < 32'(STORE);
	assign fade_prod = 16'(fade_row_q) * 16'(gradient_slope_q);

	always_comb begin
		if (!in_store) begin
			read_val = 8'h00;
		end else if (gradient_on_q && rd_q != 8'h00) begin
			read_val = 8'd254 - fade_prod[7:0];
		end else begin
			read_val = rd_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			pixel <= cmd.res_read ? read_val : 8'h00;
		end
	end

	assign status.clr_last = clr_col_end && clr_row_end;
	assign status.pix_last = cnt_q == CNT_W'(1);
	assign status.row_last = row_q == info_q.rows - 1'b1;

endmodule

`default_nettype wire

/* src/smbs_ctrl.sv */
`default_nettype none

module smbs_ctrl
	import smbs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	input  wire logic [1:0]   item_kind,
	output logic              item_ready,
	output logic              result_valid,
	input  wire logic         result_ready,
	input  wire smbs_status_t status,
	output smbs_cmd_t         cmd
);

	smbs_state_t state_q;
	smbs_state_t state_d;
	logic [1:0]  kind_q;
	logic        result_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// kind of the transaction in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
		end else if (cmd.load) begin
			kind_q <= item_kind;
		end
	end

	// result valid, set on load and cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign item_ready   = state_q == ST_IDLE;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					unique case (item_kind)
						KIND_CLEAR: state_d = ST_CLEAR;
						KIND_STAMP: state_d = ST_STAMP_ROW;
						KIND_READ:  state_d = ST_READ;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: begin
				cmd.clr_step  = 1'b1;
				cmd.clr_frame = 1'b1;
				if (status.clr_last) begin
					state_d = ST_DONE;
				end
			end
			ST_STAMP_ROW: begin
				cmd.row_load = 1'b1;
				state_d      = ST_STAMP_PIX;
			end
			ST_STAMP_PIX: begin
				cmd.pix_step = 1'b1;
				if (status.pix_last) begin
					state_d = status.row_last ? ST_DONE : ST_STAMP_ROW;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					cmd.res_load = 1'b1;
					cmd.res_read = kind_q == KIND_READ;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

/* src/shadow_mask_blob_stamper.sv */
`default_nettype none

// Shadow mask blob stamper: a MASK_SIDE x MASK_SIDE byte mask in one single-port
// memory, one write per clock. After reset a clearing pass over the whole mask
// runs before the first transaction is taken; configuration writes are accepted
// throughout. A clear transaction writes every byte of the mask, one per clock.
// A stamp walks each shape row with a setup step and then one write per covered
// pixel. A read goes through accept, memory read with the row for the fade taken
// by a reciprocal multiplication, and result. Each transaction returns one result;
// a new transaction is taken while the previous result still waits at the output.

module shadow_mask_blob_stamper
	import smbs_pkg::*;
#(
	parameter int MASK_SIDE = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	smbs_item_if.sink       item,
	smbs_result_if.source   result,
	input  wire logic       wr_en,
	input  wire logic [1:0] wr_index,
	input  wire logic [7:0] wr_data
);

	smbs_cmd_t    cmd;
	smbs_status_t status;

	// sequencer
	smbs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_kind    (item.kind),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	// mask memory, walk counters and read path
	smbs_datapath #(
		.MASK_SIDE (MASK_SIDE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.shape         (item.shape),
		.center_col    (item.center_col),
		.center_offset (item.center_offset),
		.read_address  (item.read_address),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.pixel         (result.pixel)
	);

endmodule

`default_nettype wire

/* sim/shadow_mask_blob_stamper_tb.sv */
`default_nettype none

module shadow_mask_blob_stamper_tb;
	import smbs_pkg::*;

	localparam int CLK_PERIOD     = 8;
	localparam int SIDE           = 64;
	localparam int STORE_BYTES    = SIDE * SIDE;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TIMEOUT_CYCLES = 2_000_000;
	localparam int PHASE_ITEMS    = 150;

	// kind code with no action, not named in the package
	localparam logic [1:0] KIND_NONE = 2'd3;

	// one row of stimulus: either a register write or an input transaction
	typedef struct packed {
		logic               is_cfg;
		logic [1:0]         reg_index;
		logic [7:0]         reg_data;
		logic [1:0]         kind;
		logic [2:0]         shape;
		logic signed [15:0] col;
		logic signed [15:0] off;
		logic [11:0]        addr;
		logic               typed;
		logic [7:0]         pixel;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en;
	logic [1:0] wr_index;
	logic [7:0] wr_data;

	smbs_item_if   item_bus ();
	smbs_result_if result_bus ();

	shadow_mask_blob_stamper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_bus),
		.result   (result_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// blob geometry, indexed by shape code
	int blob_rows   [5]     = '{7, 8, 12, 6, 14};
	int blob_first  [5]     = '{3, 4, 6, 2, 7};
	int blob_narrow [5]     = '{1, 0, 0, 1, 0};
	int blob_half   [5][14] = '{
		'{2, 3, 4, 4, 4, 3, 2, 0, 0, 0, 0, 0, 0, 0},
		'{2, 3, 4, 4, 4, 4, 3, 2, 0, 0, 0, 0, 0, 0},
		'{2, 4, 5, 5, 6, 6, 6, 6, 5, 5, 4, 2, 0, 0},
		'{1, 2, 3, 3, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{2, 4, 5, 6, 7, 8, 8, 8, 8, 7, 6, 5, 4, 2}
	};

	// mirror of the mask and the registers
	logic [7:0] shadow_mask [STORE_BYTES];
	logic       frame_on;
	logic       fade_on;
	logic [7:0] fade_slope;

	logic [7:0] pending_pixels [$];
	stim_row_t  directed_rows [$];
	int         errors = 0;
	bit         calm = 1'b0;
	int         last_col = 32;
	int         last_row = 32;

	// clear pass: zeros, or a 255 rim when the frame mode is on
	function automatic void mask_clear();
		int a;
		bit on_rim;
		for (a = 0; a < STORE_BYTES; a++) begin
			on_rim = (a / SIDE == 0) || (a / SIDE == SIDE - 1) ||
				(a % SIDE == 0) || (a % SIDE == SIDE - 1);
			shadow_mask[a] = (frame_on && on_rim) ? 8'hFF : 8'h00;
		end
	endfunction

	// stamp a blob with column, row-offset and final-address clipping
	function automatic void mask_stamp(input logic [2:0] shape, input int ccol, input int coff);
		int s, r, row_off, w, stop, d, c;
		s = (shape <= SHAPE_ROW14) ? int'(shape) : int'(SHAPE_ROW6);
		for (r = 0; r < blob_rows[s]; r++) begin
			row_off = coff + (r - blob_first[s]) * SIDE;
			w = blob_half[s][r];
			stop = blob_narrow[s] ? w - 1 : w;
			if (row_off >= 0 && row_off < STORE_BYTES) begin
				for (d = -w; d < stop; d++) begin
					c = ccol + d;
					if (c >= 0 && c < SIDE && c + row_off < STORE_BYTES)
						shadow_mask[c + row_off] = 8'hFF;
				end
			end
		end
	endfunction

	// apply one transaction to the mirror and return the pixel it yields
	function automatic logic [7:0] predict_pixel(input stim_row_t r);
		logic [7:0] v;
		int ccol, coff;
		ccol = $signed(r.col);
		coff = $signed(r.off);
		v = 8'h00;
		if (r.kind == KIND_CLEAR) begin
			mask_clear();
		end else if (r.kind == KIND_STAMP) begin
			mask_stamp(r.shape, ccol, coff);
		end else if (r.kind == KIND_READ) begin
			v = shadow_mask[r.addr];
			if (fade_on && v != 8'h00)
				v = 8'(254 - int'(r.addr / SIDE) * int'(fade_slope));
		end
		return v;
	endfunction

	// idle length: mostly short, a few long, none in calm stretches
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic stim_row_t item_row(input logic [1:0] kind, input logic [2:0] shape,
		input int col, input int off, input int addr, input bit typed, input int pixel);
		stim_row_t r;
		r = '0;
		r.kind = kind;
		r.shape = shape;
		r.col = 16'(col);
		r.off = 16'(off);
		r.addr = 12'(addr);
		r.typed = typed;
		r.pixel = 8'(pixel);
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [1:0] idx, input int data);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_index = idx;
		r.reg_data = 8'(data);
		return r;
	endfunction

	// random transaction: mostly on-mask stamps and reads near the last blob
	function automatic stim_row_t random_item();
		stim_row_t r;
		int roll, c, row;
		r = '0;
		r.shape = 3'($urandom);
		r.col = 16'($urandom);
		r.off = 16'($urandom);
		r.addr = 12'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 2)
			r.kind = KIND_CLEAR;
		else if (roll < 47)
			r.kind = KIND_STAMP;
		else if (roll < 50)
			r.kind = KIND_NONE;
		else
			r.kind = KIND_READ;

		if (r.kind == KIND_STAMP) begin
			if ($urandom_range(0, 9) < 7) begin
				r.shape = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
					3'($urandom_range(0, 4));
				c = $urandom_range(0, 83) - 10;
				row = $urandom_range(0, 95) - 16;
				r.col = 16'(c);
				r.off = 16'(row * SIDE);
				if ($urandom_range(0, 4) == 0)
					r.off = 16'(row * SIDE + $urandom_range(0, 126) - 63);
				last_col = c;
				last_row = row;
			end else begin
				last_col = $signed(r.col);
				last_row = $signed(r.off) >>> 6;
			end
		end else if (r.kind == KIND_READ && $urandom_range(0, 9) < 6) begin
			r.addr = {6'(last_row + $urandom_range(0, 16) - 8),
				6'(last_col + $urandom_range(0, 18) - 9)};
		end
		return r;
	endfunction

	// hold the sender until every result is back and the block is idle
	task automatic drain_results();
		@(negedge clk);
		item_bus.valid = 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		case (idx)
			REG_BORDER_FRAME:   frame_on = data[0];
			REG_GRADIENT_ON:    fade_on = data[0];
			REG_GRADIENT_SLOPE: fade_slope = data;
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// drive one transaction and record its expected pixel once accepted
	task automatic send_item(input stim_row_t r);
		int gap;
		logic [7:0] want;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			item_bus.valid = 1'b0;
		end
		@(negedge clk);
		item_bus.valid = 1'b1;
		item_bus.kind = r.kind;
		item_bus.shape = r.shape;
		item_bus.center_col = r.col;
		item_bus.center_offset = r.off;
		item_bus.read_address = r.addr;
		do @(posedge clk); while (!item_bus.ready);
		want = predict_pixel(r);
		pending_pixels.push_back(r.typed ? r.pixel : want);
	endtask

	task automatic run_directed();
		stim_row_t r;
		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.is_cfg) begin
				drain_results();
				write_reg(r.reg_index, r.reg_data);
			end else begin
				send_item(r);
			end
		end
	endtask

	// result side: random stalls, compare against the oldest expectation
	initial begin : result_side
		int gap;
		logic [7:0] want;
		result_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			repeat (gap) begin
				@(negedge clk);
				result_bus.ready = 1'b0;
			end
			@(negedge clk);
			result_bus.ready = 1'b1;
			do @(posedge clk); while (!result_bus.valid);
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t unexpected transaction: expected none, actual pixel %0d",
					$time, result_bus.pixel);
			end else begin
				want = pending_pixels.pop_front();
				if (result_bus.pixel !== want) begin
					errors++;
					$display("%0t pixel mismatch: expected %0d, actual %0d",
						$time, want, result_bus.pixel);
				end
			end
		end
	end

	// main sequence
	initial begin : stimulus
		int p, i;
		logic [7:0] slope_pick;
		item_bus.valid = 1'b0;
		item_bus.kind = KIND_CLEAR;
		item_bus.shape = SHAPE_ROW7;
		item_bus.center_col = '0;
		item_bus.center_offset = '0;
		item_bus.read_address = '0;
		wr_en = 1'b0;
		wr_index = REG_BORDER_FRAME;
		wr_data = '0;
		frame_on = 1'b0;
		fade_on = 1'b0;
		fade_slope = SLOPE_RESET;
		foreach (shadow_mask[a])
			shadow_mask[a] = 8'h00;

		// directed rows under the reset register values
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 0, 1, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 4095, 1, 0));
		directed_rows.push_back(item_row(KIND_STAMP, SHAPE_ROW7, 10, 640, 0, 1, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 650, 1, 255));
		// blobs clipped at the corners and at the field extremes
		directed_rows.push_back(item_row(KIND_STAMP, SHAPE_ROW8, 0, 0, 0, 1, 0));
		directed_rows.push_back(item_row(KIND_STAMP, SHAPE_ROW12, 63, 4032, 0, 1, 0));
		directed_rows.push_back(item_row(KIND_STAMP, SHAPE_ROW6, -32768, -32768, 0, 1, 0));
		directed_rows.push_back(item_row(KIND_STAMP, SHAPE_ROW14, 32767, 32767, 0, 1, 0));
		// unknown shape codes fall back to the six-row blob
		directed_rows.push_back(item_row(KIND_STAMP, 3'd5, 30, 1920, 0, 1, 0));
		// row offset not row aligned: last bytes blocked by the address limit
		directed_rows.push_back(item_row(KIND_STAMP, 3'd7, 8, 4090, 0, 1, 0));
		directed_rows.push_back(item_row(KIND_NONE, 3'd7, -1, -1, 4095, 1, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 4095, 0, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 4093, 0, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 1952, 0, 0));
		// blob hanging over the top of the mask
		directed_rows.push_back(item_row(KIND_STAMP, SHAPE_ROW14, 20, -128, 0, 1, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 20, 0, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 63, 0, 0));
		// framed clear with the steepest fade
		directed_rows.push_back(cfg_row(REG_BORDER_FRAME, 1));
		directed_rows.push_back(cfg_row(REG_GRADIENT_ON, 1));
		directed_rows.push_back(cfg_row(REG_GRADIENT_SLOPE, 255));
		directed_rows.push_back(item_row(KIND_CLEAR, SHAPE_ROW7, 0, 0, 0, 1, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 0, 1, 254));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 4095, 0, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 650, 0, 0));
		// flat fade, then fade off
		directed_rows.push_back(cfg_row(REG_GRADIENT_SLOPE, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 4032, 1, 254));
		directed_rows.push_back(cfg_row(REG_GRADIENT_ON, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 64, 1, 255));
		directed_rows.push_back(cfg_row(REG_BORDER_FRAME, 0));
		directed_rows.push_back(item_row(KIND_CLEAR, SHAPE_ROW7, 0, 0, 0, 1, 0));
		directed_rows.push_back(item_row(KIND_READ, SHAPE_ROW7, 0, 0, 0, 1, 0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();

		// random phases, each under its own register setting
		for (p = 0; p < 6; p++) begin
			drain_results();
			case (p)
				0: slope_pick = 8'd0;
				1: slope_pick = 8'd255;
				2: slope_pick = 8'd128;
				3: slope_pick = 8'd1;
				default: slope_pick = 8'($urandom);
			endcase
			write_reg(REG_BORDER_FRAME, 8'(p != 1 && p != 4));
			write_reg(REG_GRADIENT_ON, 8'(p != 2));
			write_reg(REG_GRADIENT_SLOPE, slope_pick);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 50 == 0)
					calm = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 49) == 0)
					drain_results();
				send_item(random_item());
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("%0t run limit reached, %0d transactions still expected",
			$time, pending_pixels.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
